// ===== rtl/core/fws_pkg.sv =====
// package: actions, status codes and shared types for the statistics fifo
package fws_pkg;
   typedef enum logic [1:0] {
      ACT_ENQ  = 2'd0,
      ACT_DEQ  = 2'd1,
      ACT_STAT = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ,
      S_LOAD,
      S_SORT,
      S_MED,
      S_RSP
   } state_type;

   localparam int VAL_W = 31;
   localparam int CNT_W = 5;
   localparam int SUM_W = 35;
   localparam int MED_W = 32;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
endpackage

// ===== rtl/core/fws_ram.sv =====
// generic simple dual-port ram (separate write and read address) with registered read
module fws_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/fws_sorter.sv =====
// insertion sorter: a row of cells that keeps loaded words in ascending order
module fws_sorter
   import fws_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             clear,
   input  logic             load,
   input  logic [VAL_W-1:0] load_value,
   input  logic [$clog2(DEPTH)-1:0] sel_a,
   input  logic [$clog2(DEPTH)-1:0] sel_b,
   output logic [VAL_W-1:0] med_a,
   output logic [VAL_W-1:0] med_b
);
   logic [VAL_W-1:0] cell_ff [DEPTH];
   logic [VAL_W-1:0] cell_in [DEPTH];
   logic [DEPTH-1:0] used_ff;
   logic [DEPTH-1:0] used_in;
   logic [DEPTH-1:0] gt;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = used_ff[i] && (cell_ff[i] > load_value);
      end
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         used_in[i] = used_ff[i];
         if (load) begin
            if (i == 0) begin
               if (gt[0] || !used_ff[0]) begin
                  cell_in[0] = load_value;
               end
            end else if (gt[i-1]) begin
               cell_in[i] = cell_ff[i-1];
            end else if (gt[i] || !used_ff[i]) begin
               cell_in[i] = load_value;
            end
            if (i == 0) begin
               used_in[0] = 1'b1;
            end else begin
               used_in[i] = used_ff[i] | used_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign med_a = cell_ff[sel_a];
   assign med_b = cell_ff[sel_b];
endmodule

// ===== rtl/core/fifo_with_statistics.sv =====
// top level: fifo with count, min, max, sum and median report
// response path: enqueue and code 3 go through S_RSP to the registered strobe, dequeue passes S_DEQ first
// statistics read the ram once per entry into the sorting cells, then pass S_SORT and S_MED
// busy is high until the result strobe, so one request is handled at a time, never stalled
// synchronous active-high reset empties the queue; ram contents are not cleared
module fifo_with_statistics
   import fws_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [VAL_W-1:0]      req_value,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [VAL_W-1:0]      rsp_out_value,
   output logic [CNT_W-1:0]      rsp_stat_count,
   output logic [VAL_W-1:0]      rsp_stat_min,
   output logic [VAL_W-1:0]      rsp_stat_max,
   output logic [SUM_W-1:0]      rsp_stat_sum,
   output logic [MED_W-1:0]      rsp_stat_median_x2
);
   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in, ptr_ff, ptr_in;
   logic [FW-1:0] fill_ff, fill_in, left_ff, left_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [VAL_W-1:0] min_ff, min_in, max_ff, max_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [1:0]       st_ff, st_in;
   logic [VAL_W-1:0] ov_ff, ov_in;
   logic [MED_W-1:0] med_ff, med_in;
   logic             stat_ff, stat_in;
   logic             strobe_ff, strobe_in;

   logic             wr_en;
   logic [AW-1:0]    rd_addr;
   logic [VAL_W-1:0] rd_data, med_a, med_b;
   logic             sort_clear, sort_load;
   logic [AW-1:0]    sel_a, sel_b;
   logic [FW-1:0]    half;
   logic             accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign wr_en  = accept && (req_action == ACT_ENQ) && (fill_ff != FW'(DEPTH));
   assign rd_addr = (state_ff == S_IDLE) ? head_ff : ptr_ff;
   assign half   = fill_ff >> 1;
   assign sel_a  = AW'(half);
   assign sel_b  = AW'(half - FW'(1));

   fws_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fws_sorter #(.DEPTH(DEPTH)) u_sorter (
      .clock      (clock),
      .clear      (sort_clear),
      .load       (sort_load),
      .load_value (rd_data),
      .sel_a      (sel_a),
      .sel_b      (sel_b),
      .med_a      (med_a),
      .med_b      (med_b)
   );

   always_comb begin
      state_in = state_ff;
      head_in = head_ff; tail_in = tail_ff; fill_in = fill_ff;
      ptr_in = ptr_ff; left_in = left_ff; rd_pend_in = 1'b0;
      min_in = min_ff; max_in = max_ff; sum_in = sum_ff;
      st_in = st_ff; ov_in = ov_ff; med_in = med_ff; stat_in = stat_ff;
      strobe_in = 1'b0;
      sort_clear = 1'b0; sort_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               st_in = ST_DONE; ov_in = '0; stat_in = 1'b0; med_in = '0;
               case (req_action)
                  ACT_ENQ: begin
                     if (fill_ff == FW'(DEPTH)) begin
                        st_in = ST_FULL;
                     end else begin
                        tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
                        fill_in = fill_ff + FW'(1);
                     end
                     state_in = S_RSP;
                  end
                  ACT_DEQ: begin
                     if (fill_ff == '0) begin
                        st_in = ST_EMPTY;
                        state_in = S_RSP;
                     end else begin
                        state_in = S_DEQ;
                     end
                  end
                  ACT_STAT: begin
                     stat_in = 1'b1;
                     sort_clear = 1'b1;
                     min_in = VAL_MAX; max_in = '0; sum_in = '0;
                     ptr_in = head_ff; left_in = fill_ff;
                     state_in = S_LOAD;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_DEQ: begin
            ov_in = rd_data;
            head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
            fill_in = fill_ff - FW'(1);
            state_in = S_RSP;
         end
         S_LOAD: begin
            if (rd_pend_ff) begin
               sort_load = 1'b1;
               if (rd_data < min_ff) min_in = rd_data;
               if (rd_data > max_ff) max_in = rd_data;
               sum_in = sum_ff + SUM_W'(rd_data);
            end
            if (left_ff != '0) begin
               rd_pend_in = 1'b1;
               left_in = left_ff - FW'(1);
               ptr_in = (ptr_ff == AW'(DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
            end else if (!rd_pend_ff) begin
               state_in = S_SORT;
            end else begin
               state_in = S_SORT;
            end
         end
         S_SORT: state_in = S_MED;
         S_MED: begin
            if (fill_ff == '0) begin
               med_in = '0;
            end else if (fill_ff[0]) begin
               med_in = {med_a, 1'b0};
            end else begin
               med_in = MED_W'(med_a) + MED_W'(med_b);
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0; tail_ff <= '0; fill_ff <= '0;
         rd_pend_ff <= 1'b0; strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; tail_ff <= tail_in; fill_ff <= fill_in;
         rd_pend_ff <= rd_pend_in; strobe_ff <= strobe_in;
      end
      ptr_ff <= ptr_in; left_ff <= left_in;
      min_ff <= min_in; max_ff <= max_in; sum_ff <= sum_in;
      st_ff <= st_in; ov_ff <= ov_in; med_ff <= med_in; stat_ff <= stat_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = strobe_ff ? st_ff : '0;
   assign rsp_out_value      = ov_ff;
   assign rsp_stat_count     = stat_ff ? CNT_W'(fill_ff) : '0;
   assign rsp_stat_min       = stat_ff ? min_ff : '0;
   assign rsp_stat_max       = stat_ff ? max_ff : '0;
   assign rsp_stat_sum       = stat_ff ? sum_ff : '0;
   assign rsp_stat_median_x2 = stat_ff ? med_ff : '0;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH)) else $error("fill count above depth");
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while still busy");
   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_ENQ && fill_ff == FW'(DEPTH)) |=> $stable(fill_ff))
      else $error("refused enqueue changed the fill count");
endmodule
